// ===== hw/rtl/tbt_pkg.sv =====
// Shared types, constants and tables of the target bearing tracker.
`default_nettype none
package tbt_pkg;

  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic [49:0] DIST_MAX    = {50{1'b1}};
  localparam int          HALF_PI_Q16 = 102944;
  localparam int          PI_Q13      = 25736;

  // Configuration register indexes
  localparam logic [7:0] REG_LIFETIME = 8'd0;
  localparam logic [7:0] REG_VEL_EPS  = 8'd1;
  localparam logic [7:0] REG_MIN_DIST = 8'd2;
  localparam logic [7:0] REG_DEADBAND = 8'd3;

  typedef enum logic [1:0] {
    MODE_PRI  = 2'd0,
    MODE_SEC  = 2'd1,
    MODE_VEL  = 2'd2,
    MODE_TICK = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ1, S_SQ2, S_DUPD, S_TICK, S_TCHK, S_TEVAL,
    S_AIM, S_CINIT, S_CSTEP, S_CFIN, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ1, OP_SQ2, OP_DUPD, OP_TICK,
    OP_AIM, OP_CINIT, OP_CSTEP, OP_CFIN, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  p_held;
    logic  held;
    logic  vel_valid;
    logic  below_thr;
    logic  zero_vec;
    logic  last_step;
    logic  db_fail;
    logic  out_free;
  } dp_status_t;

  // atan(2^-i) in Q16 radians
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30386;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tbt_ctrl.sv =====
// Sequencing state machine of the target bearing tracker.
`default_nettype none
module tbt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          in_mode_i,
  output logic                     in_ready_o,
  input  wire tbt_pkg::dp_status_t status_i,
  output tbt_pkg::dp_cmd_t         cmd_o
);
  import tbt_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          case (mode_e'(in_mode_i))
            MODE_PRI:  state_d = S_SQ1;
            MODE_SEC:  state_d = status_i.p_held ? S_IDLE : S_SQ1;
            MODE_TICK: state_d = S_TICK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SQ1: begin
        cmd_o.op = OP_SQ1;
        state_d  = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.op = OP_SQ2;
        state_d  = (status_i.mode == MODE_TICK) ? S_TEVAL : S_DUPD;
      end
      S_DUPD: begin
        cmd_o.op = OP_DUPD;
        state_d  = S_IDLE;
      end
      S_TICK: begin
        cmd_o.op = OP_TICK;
        state_d  = S_TCHK;
      end
      S_TCHK: begin
        state_d = (!status_i.held && !status_i.vel_valid) ? S_IDLE : S_SQ1;
      end
      S_TEVAL: begin
        if (status_i.below_thr) begin
          state_d = S_IDLE;
        end else begin
          state_d = status_i.held ? S_AIM : S_CINIT;
        end
      end
      S_AIM: begin
        cmd_o.op = OP_AIM;
        state_d  = S_CINIT;
      end
      S_CINIT: begin
        if (status_i.zero_vec) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_CINIT;
          state_d  = S_CSTEP;
        end
      end
      S_CSTEP: begin
        cmd_o.op = OP_CSTEP;
        if (status_i.last_step) state_d = S_CFIN;
      end
      S_CFIN: begin
        cmd_o.op = OP_CFIN;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.db_fail) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tbt_dp.sv =====
// Datapath of the target bearing tracker: state, squares and CORDIC atan2.
`default_nettype none
module tbt_dp #(
  parameter int unsigned CordicSteps = tbt_pkg::CORDIC_STEPS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tbt_pkg::dp_cmd_t    cmd_i,
  output tbt_pkg::dp_status_t      status_o,
  input  wire logic [1:0]          in_mode_i,
  input  wire logic                in_last_i,
  input  wire logic [95:0]         in_data_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [7:0]          cfg_addr_i,
  input  wire logic [15:0]         cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [15:0]              out_data_o
);
  import tbt_pkg::*;

  localparam int unsigned CntW = $clog2(CordicSteps);

  // Configuration
  logic [9:0]  lifetime_q;
  logic [15:0] vel_eps_q, min_dist_q;
  logic [14:0] deadband_q;

  // Tracker state
  logic signed [23:0] target_x_q, target_y_q, best_x_q, best_y_q, vel_x_q, vel_y_q;
  logic [49:0] best_q;
  logic [9:0]  age_q;
  logic        p_held_q, s_held_q, vel_valid_q;

  // Working registers
  mode_e              mode_q;
  logic               last_q;
  logic signed [23:0] px_q, py_q, rx_q, ry_q;
  logic signed [24:0] ax_q, ay_q;
  logic [48:0]        p_q;
  logic [49:0]        sum_q;
  logic [15:0]        thr_q;
  logic [31:0]        thr_sq_q;
  logic signed [27:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [15:0] bearing_q;
  logic               out_valid_q;
  logic [15:0]        out_q;

  logic signed [23:0] in_px, in_py, in_rx, in_ry;
  logic signed [49:0] sqx, sqy;
  logic [9:0]         age_inc;
  logic               tmo, held_next;
  logic signed [27:0] xs, ys, ax_w, ay_w;
  logic signed [19:0] at_w, zr_w;
  logic signed [16:0] zs;
  logic signed [15:0] bclamp;
  logic [15:0]        bmag;

  assign in_px = in_data_i[23:0];
  assign in_py = in_data_i[47:24];
  assign in_rx = in_data_i[71:48];
  assign in_ry = in_data_i[95:72];

  // Arithmetic shared by the steps
  always_comb begin
    sqx     = ax_q * ax_q;
    sqy     = ay_q * ay_q;
    age_inc = (age_q == 10'h3FF) ? age_q : age_q + 10'd1;
    tmo     = age_inc > lifetime_q;
    held_next = (p_held_q || s_held_q) && !tmo;
    xs      = cx_q >>> cnt_q;
    ys      = cy_q >>> cnt_q;
    at_w    = 20'(signed'({1'b0, atan_q16(5'(cnt_q))}));
    ax_w    = 28'(ax_q);
    ay_w    = 28'(ay_q);
    zr_w    = (cz_q + 20'sd4) >>> 3;
    zs      = zr_w[16:0];
    if (zs > 17'sd25736)       bclamp = 16'sd25736;
    else if (zs < -17'sd25736) bclamp = -16'sd25736;
    else                       bclamp = zs[15:0];
    bmag    = bearing_q[15] ? 16'(-bearing_q) : 16'(bearing_q);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= 10'd22;
      vel_eps_q  <= 16'd102;
      min_dist_q <= 16'd205;
      deadband_q <= 15'd205;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_LIFETIME: lifetime_q <= cfg_data_i[9:0];
        REG_VEL_EPS:  vel_eps_q  <= cfg_data_i;
        REG_MIN_DIST: min_dist_q <= cfg_data_i;
        REG_DEADBAND: deadband_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Tracker state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q  <= '0;
      target_y_q  <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      best_q      <= DIST_MAX;
      age_q       <= '0;
      p_held_q    <= 1'b0;
      s_held_q    <= 1'b0;
      vel_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise on a new result, drop once the waiting one is taken
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if (mode_e'(in_mode_i) == MODE_VEL) begin
            vel_x_q     <= in_px;
            vel_y_q     <= in_py;
            vel_valid_q <= 1'b1;
          end
        end
        OP_DUPD: begin
          if (last_q) begin
            // Commit the candidate, or the new item if it is nearer
            target_x_q <= (sum_q < best_q) ? px_q : best_x_q;
            target_y_q <= (sum_q < best_q) ? py_q : best_y_q;
            age_q      <= '0;
            best_q     <= DIST_MAX;
            if (mode_q == MODE_PRI) begin
              p_held_q <= 1'b1;
              s_held_q <= 1'b0;
            end else begin
              s_held_q <= 1'b1;
            end
          end else if (sum_q < best_q) begin
            best_q   <= sum_q;
            best_x_q <= px_q;
            best_y_q <= py_q;
          end
        end
        OP_TICK: begin
          age_q <= age_inc;
          if (tmo) begin
            p_held_q <= 1'b0;
            s_held_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= mode_e'(in_mode_i);
        last_q <= in_last_i;
        px_q   <= in_px;
        py_q   <= in_py;
        rx_q   <= in_rx;
        ry_q   <= in_ry;
        ax_q   <= 25'(in_px) - 25'(in_rx);
        ay_q   <= 25'(in_py) - 25'(in_ry);
      end
      OP_SQ1: begin
        p_q      <= sqx[48:0];
        thr_sq_q <= thr_q * thr_q;
      end
      OP_SQ2: sum_q <= {1'b0, p_q} + sqy;
      OP_TICK: begin
        ax_q  <= held_next ? 25'(target_x_q) : 25'(vel_x_q);
        ay_q  <= held_next ? 25'(target_y_q) : 25'(vel_y_q);
        thr_q <= held_next ? min_dist_q : vel_eps_q;
      end
      OP_AIM: begin
        ax_q <= 25'(target_x_q) - 25'(rx_q);
        ay_q <= 25'(target_y_q) - 25'(ry_q);
      end
      OP_CINIT: begin
        cnt_q <= '0;
        // Rotate into the right half plane
        if (ax_q < 0) begin
          if (ay_q >= 0) begin
            cx_q <= ay_w;
            cy_q <= -ax_w;
            cz_q <= 20'sd102944;
          end else begin
            cx_q <= -ay_w;
            cy_q <= ax_w;
            cz_q <= -20'sd102944;
          end
        end else begin
          cx_q <= ax_w;
          cy_q <= ay_w;
          cz_q <= '0;
        end
      end
      OP_CSTEP: begin
        cnt_q <= cnt_q + 1'b1;
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at_w;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at_w;
        end
      end
      OP_CFIN: bearing_q <= bclamp;
      OP_EMIT: out_q <= bearing_q;
      default: ;
    endcase
  end

  always_comb begin
    status_o.mode      = mode_q;
    status_o.p_held    = p_held_q;
    status_o.held      = p_held_q || s_held_q;
    status_o.vel_valid = vel_valid_q;
    status_o.below_thr = sum_q < {18'd0, thr_sq_q};
    status_o.zero_vec  = (ax_q == '0) && (ay_q == '0);
    status_o.last_step = cnt_q == CntW'(CordicSteps - 1);
    status_o.db_fail   = bmag < {1'b0, deadband_q};
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result written over a waiting one");
  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DUPD && last_q) |=> (best_q == DIST_MAX))
    else $error("candidate not cleared after commit");
  a_one_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_held_q && s_held_q))
    else $error("both sensors held at once");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/target_bearing_tracker_top.sv =====
// Top level of the target bearing tracker.
//
// Channel  | Dir | Signals                                  | Request
// s_axis   | in  | tvalid/tready, tdata, tuser=mode, tlast  | one detection, velocity or tick
// m_axis   | out | tvalid/tready, tdata=bearing             | one pan bearing
// cfg      | in  | cfg_valid_i/cfg_ready_o, addr, data      | one register write
//
// One request is taken at a time, and the next only once the last is done;
// ticks run the iterative CORDIC loop.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result waits in the output register while the next request is
// taken; a new result then waits for it to leave.
`default_nettype none
module target_bearing_tracker_top #(
  parameter int unsigned CordicSteps = tbt_pkg::CORDIC_STEPS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // pos_x, pos_y, ref_x, ref_y
  input  wire logic [1:0]  s_axis_tuser,  // mode
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // bearing
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);
  import tbt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tbt_dp #(
    .CordicSteps (CordicSteps)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_mode_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
